FILE: rtl/core/dvsd_pkg.sv
// ----------------------------------------------------------------------------
// dvsd_pkg
// Shared codes and types for the DLE voice stream deframer.
// ----------------------------------------------------------------------------
package dvsd_pkg;

   localparam logic [7:0] CODE_DLE = 8'h10;
   localparam logic [7:0] CODE_SUB = 8'h1A;
   localparam logic [7:0] CODE_ETX = 8'h03;

   localparam int BYTE_W  = 8;
   localparam int EVENT_W = 5;

   // Line event numbers
   localparam logic [EVENT_W-1:0] EV_BONG          = 5'd0;
   localparam logic [EVENT_W-1:0] EV_DTMF          = 5'd1;
   localparam logic [EVENT_W-1:0] EV_DATA_FAX      = 5'd2;
   localparam logic [EVENT_W-1:0] EV_BUSY          = 5'd3;
   localparam logic [EVENT_W-1:0] EV_FAX_CALLING   = 5'd4;
   localparam logic [EVENT_W-1:0] EV_DIAL_TONE     = 5'd5;
   localparam logic [EVENT_W-1:0] EV_DATA_CALLING  = 5'd6;
   localparam logic [EVENT_W-1:0] EV_HOOK_ON       = 5'd7;
   localparam logic [EVENT_W-1:0] EV_HOOK_OFF      = 5'd8;
   localparam logic [EVENT_W-1:0] EV_LOOP_BREAK    = 5'd9;
   localparam logic [EVENT_W-1:0] EV_SIT_TONE      = 5'd10;
   localparam logic [EVENT_W-1:0] EV_LOOP_POLARITY = 5'd11;
   localparam logic [EVENT_W-1:0] EV_SILENCE       = 5'd12;
   localparam logic [EVENT_W-1:0] EV_RINGBACK      = 5'd13;
   localparam logic [EVENT_W-1:0] EV_RING          = 5'd14;
   localparam logic [EVENT_W-1:0] EV_NO_VOICE      = 5'd15;
   localparam logic [EVENT_W-1:0] EV_TDD           = 5'd16;
   localparam logic [EVENT_W-1:0] EV_VOICE         = 5'd17;
   localparam logic [EVENT_W-1:0] EV_CALL_WAITING  = 5'd18;
   localparam logic [EVENT_W-1:0] EV_NONE          = 5'd0;

   typedef enum logic [2:0] {
      KIND_DATA    = 3'd0,
      KIND_EVENT   = 3'd1,
      KIND_END     = 3'd2,
      KIND_NOTICE  = 3'd3,
      KIND_UNKNOWN = 3'd4
   } kind_type;

   // Classification of the code byte that follows a DLE
   typedef struct packed {
      kind_type             kind;
      logic [EVENT_W-1:0]   event_code;
   } code_class_type;

endpackage

FILE: rtl/core/dle_voice_stream_deframer.sv
// ----------------------------------------------------------------------------
// dle_voice_stream_deframer
// Path: an accepted input beat is held in the input register, then decoded into the result register.
// Throughput: one input beat per cycle while the output is not stalled; DLE SUB
// emits two result beats and holds the input side until the second one is taken.
// Reset: synchronous, clears the escape and end-of-stream flags and empties
// the input and result registers.
// ----------------------------------------------------------------------------
module dle_voice_stream_deframer
   import dvsd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,

   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] in_byte
   input  logic        req_tuser,   // [0] start_of_stream

   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [7:0] out_byte, [12:8] event_code, [15:13] zero
   output logic [2:0]  rsp_tuser,   // [2:0] kind
   output logic        rsp_tlast    // last
);

   // input register
   logic               in_valid_ff, in_valid_in;
   logic [BYTE_W-1:0]  in_byte_ff;
   logic               in_sos_ff;

   // stream state
   logic               esc_ff, esc_in;
   logic               ended_ff, ended_in;

   // result register
   logic               rsp_valid_ff, rsp_valid_in;
   kind_type           rsp_kind_ff, rsp_kind_in;
   logic [BYTE_W-1:0]  rsp_byte_ff, rsp_byte_in;
   logic [EVENT_W-1:0] rsp_event_ff, rsp_event_in;
   logic               rsp_last_ff, rsp_last_in;
   logic               dup_ff, dup_in;

   logic               out_free;
   logic               advance;
   logic               req_take;
   logic               rsp_take;
   logic               esc_cur;
   logic               ended_cur;
   logic               has_result;
   logic               res_dup;
   kind_type           res_kind;
   logic [BYTE_W-1:0]  res_byte;
   logic [EVENT_W-1:0] res_event;
   code_class_type     code_class;

   dvsd_classify u_classify (
      .code_byte  (in_byte_ff),
      .code_class (code_class)
   );

   assign rsp_take   = rsp_valid_ff && rsp_tready;
   assign out_free   = !dup_ff && (!rsp_valid_ff || rsp_tready);
   assign advance    = in_valid_ff && out_free;
   assign req_tready = !in_valid_ff || advance;
   assign req_take   = req_tvalid && req_tready;

   // decode the held beat against the stream state
   always_comb begin
      esc_cur    = esc_ff && !in_sos_ff;
      ended_cur  = ended_ff && !in_sos_ff;
      esc_in     = esc_cur;
      ended_in   = ended_cur;
      has_result = 1'b0;
      res_dup    = 1'b0;
      res_kind   = KIND_DATA;
      res_byte   = in_byte_ff;
      res_event  = '0;
      priority if (ended_cur) begin
         // drop everything until a start flag
      end else if (!esc_cur) begin
         if (in_byte_ff == CODE_DLE) begin
            esc_in = 1'b1;
         end else begin
            has_result = 1'b1;
         end
      end else begin
         esc_in     = 1'b0;
         has_result = 1'b1;
         priority if (in_byte_ff == CODE_DLE) begin
            res_byte = CODE_DLE;
         end else if (in_byte_ff == CODE_SUB) begin
            res_byte = CODE_DLE;
            res_dup  = 1'b1;
         end else if (in_byte_ff == CODE_ETX) begin
            res_kind = KIND_END;
            ended_in = 1'b1;
         end else begin
            res_kind  = code_class.kind;
            res_event = code_class.event_code;
         end
      end
   end

   always_comb begin
      in_valid_in  = in_valid_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_kind_in  = rsp_kind_ff;
      rsp_byte_in  = rsp_byte_ff;
      rsp_event_in = rsp_event_ff;
      rsp_last_in  = rsp_last_ff;
      dup_in       = dup_ff;
      if (advance) begin
         in_valid_in = 1'b0;
      end
      if (req_take) begin
         in_valid_in = 1'b1;
      end
      priority if (rsp_take && dup_ff) begin
         // second DLE of a DLE SUB pair
         rsp_last_in = 1'b1;
         dup_in      = 1'b0;
      end else if (advance && has_result) begin
         rsp_valid_in = 1'b1;
         rsp_kind_in  = res_kind;
         rsp_byte_in  = res_byte;
         rsp_event_in = res_event;
         rsp_last_in  = !res_dup;
         dup_in       = res_dup;
      end else if (rsp_take) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         dup_ff       <= 1'b0;
         esc_ff       <= 1'b0;
         ended_ff     <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         dup_ff       <= dup_in;
         if (advance) begin
            esc_ff   <= esc_in;
            ended_ff <= ended_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_byte_ff <= req_tdata;
         in_sos_ff  <= req_tuser;
      end
      rsp_kind_ff  <= rsp_kind_in;
      rsp_byte_ff  <= rsp_byte_in;
      rsp_event_ff <= rsp_event_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {3'b000, rsp_event_ff, rsp_byte_ff};
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tlast  = rsp_last_ff;

   a_dup_has_beat: assert property (@(posedge clock) disable iff (reset)
      dup_ff |-> rsp_valid_ff)
      else $error("pending DLE duplicate without a result beat");

   a_dup_first_half: assert property (@(posedge clock) disable iff (reset)
      dup_ff |-> (rsp_kind_ff == KIND_DATA && rsp_byte_ff == CODE_DLE && !rsp_last_ff))
      else $error("first beat of a DLE SUB pair is malformed");

   a_dup_follows: assert property (@(posedge clock) disable iff (reset)
      (rsp_take && dup_ff) |=> (rsp_valid_ff && rsp_last_ff && rsp_byte_ff == CODE_DLE))
      else $error("second beat of a DLE SUB pair is missing");

   a_event_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_kind_ff != KIND_EVENT) |-> (rsp_event_ff == '0))
      else $error("event code set on a non-event beat");

endmodule

FILE: rtl/core/dvsd_classify.sv
// ----------------------------------------------------------------------------
// dvsd_classify
// Maps the code byte after a DLE to a line event, a notice or an unknown code.
// ----------------------------------------------------------------------------
module dvsd_classify
   import dvsd_pkg::*;
(
   input  logic [BYTE_W-1:0] code_byte,
   output code_class_type    code_class
);

   always_comb begin
      code_class.kind       = KIND_EVENT;
      code_class.event_code = EV_NONE;
      unique case (code_byte)
         "$": code_class.event_code = EV_BONG;
         "0", "1", "2", "3", "4", "5", "6", "7", "8", "9",
         "*", "#", "A", "B", "C", "D":
            code_class.event_code = EV_DTMF;
         "a": code_class.event_code = EV_DATA_FAX;
         "b", "K": code_class.event_code = EV_BUSY;
         "c", "m": code_class.event_code = EV_FAX_CALLING;
         "d", "i": code_class.event_code = EV_DIAL_TONE;
         "e", "f": code_class.event_code = EV_DATA_CALLING;
         "h", "p": code_class.event_code = EV_HOOK_ON;
         "H", "P": code_class.event_code = EV_HOOK_OFF;
         "I": code_class.event_code = EV_LOOP_BREAK;
         "J": code_class.event_code = EV_SIT_TONE;
         "L": code_class.event_code = EV_LOOP_POLARITY;
         "q": code_class.event_code = EV_SILENCE;
         "r": code_class.event_code = EV_RINGBACK;
         "R": code_class.event_code = EV_RING;
         "s": code_class.event_code = EV_NO_VOICE;
         "t": code_class.event_code = EV_TDD;
         "v", "V": code_class.event_code = EV_VOICE;
         "w": code_class.event_code = EV_CALL_WAITING;
         "/", "~", "E", "o", "Q", "S", "T", "u", "Y":
            code_class.kind = KIND_NOTICE;
         default:
            code_class.kind = KIND_UNKNOWN;
      endcase
   end

endmodule
